FILE: rtl/core/sphere_capsule_overlap_test_defines.svh
// ----------------------------------------------------------------------------
// Sphere/capsule overlap test: assertion macros
// Concurrent checks sampled on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPHERE_CAPSULE_OVERLAP_TEST_DEFINES_SVH
`define SPHERE_CAPSULE_OVERLAP_TEST_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SCOT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SCOT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/scot_pkg.sv
// ----------------------------------------------------------------------------
// scot_pkg
// Widths, types and vector helpers shared by the overlap test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package scot_pkg;

    localparam int COORD_BITS = 16;
    localparam int RAD_BITS   = 15;
    localparam int PT_BITS    = 48;
    localparam int NSTAGE     = 6;

    localparam int DW    = COORD_BITS + 1;    // coordinate difference
    localparam int DOTW  = 2 * DW + 2;        // dot / cross of differences
    localparam int RSW   = RAD_BITS + 1;      // radius sum
    localparam int R2W   = 2 * RSW;           // radius sum squared
    localparam int P2W   = 2 * DOTW;          // product of two dots
    localparam int WIDE  = P2W + 1;           // difference of two such products
    localparam int WNW   = DW + DOTW + 2;     // w0 . (d1 x d2)
    localparam int WN_LO = (WNW + 1) / 2;
    localparam int WN_HI = WNW - WN_LO;
    localparam int NNW   = P2W + 2;           // |d1 x d2|^2
    localparam int NN_LO = (NNW + 1) / 2;
    localparam int NN_HI = NNW - NN_LO;
    localparam int SQ_A  = 2 * WNW;
    localparam int SQ_B  = R2W + NNW;
    localparam int SQW   = ((SQ_A > SQ_B) ? SQ_A : SQ_B) + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DW-1:0]         t_diff;
    typedef logic signed [DOTW-1:0]       t_dot;
    typedef logic signed [P2W-1:0]        t_p2;
    typedef logic signed [WIDE-1:0]       t_wide;
    typedef logic signed [WNW-1:0]        t_wn;
    typedef logic [PT_BITS-1:0]           t_raw;
    typedef logic [RAD_BITS-1:0]          t_rad;
    typedef logic [RSW-1:0]               t_rsum;
    typedef logic [R2W-1:0]               t_r2;
    typedef logic [NNW-1:0]               t_nn;
    typedef logic [SQW-1:0]               t_sq;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_pt;

    typedef struct packed {
        t_diff x;
        t_diff y;
        t_diff z;
    } t_dvec;

    typedef struct packed {
        t_dot x;
        t_dot y;
        t_dot z;
    } t_nvec;

    // One shape pair as it arrives on the input channel.
    typedef struct packed {
        logic  first_is_capsule;
        t_raw  first_end_zero;
        t_raw  first_end_one;
        t_rad  first_radius;
        logic  second_is_capsule;
        t_raw  second_end_zero;
        t_raw  second_end_one;
        t_rad  second_radius;
    } t_pair;

    // Stage load enables, one per register stage.
    typedef struct packed {
        logic [NSTAGE-1:0] en;
    } t_pipe_ctl;

    // Products handed from the front half to the back half.
    typedef struct packed {
        logic [3:0]          nhit;   // endpoint test decided without products
        logic [3:0]          mid;    // endpoint test needs the product compare
        logic [3:0][P2W-1:0] wwl;
        logic [3:0][P2W-1:0] r2l;
        logic [3:0][P2W-1:0] tt;
        t_p2                 ac;
        t_p2                 bb;
        t_p2                 be;
        t_p2                 cd;
        t_p2                 ae;
        t_p2                 bd;
        logic [2:0][P2W-1:0] nsq;
        t_wn                 wn;
        t_r2                 r2;
    } t_prod;

    function automatic t_pt unpack(input t_raw raw);
        t_pt p;
        p.x = $signed(raw[COORD_BITS-1:0]);
        p.y = $signed(raw[2*COORD_BITS-1:COORD_BITS]);
        p.z = $signed(raw[3*COORD_BITS-1:2*COORD_BITS]);
        return p;
    endfunction

    function automatic t_dvec vsub(input t_pt a, input t_pt b);
        t_dvec r;
        r.x = t_diff'(a.x) - t_diff'(b.x);
        r.y = t_diff'(a.y) - t_diff'(b.y);
        r.z = t_diff'(a.z) - t_diff'(b.z);
        return r;
    endfunction

    function automatic t_dot dot3(input t_dvec a, input t_dvec b);
        t_dot s;
        s = t_dot'(a.x) * t_dot'(b.x) + t_dot'(a.y) * t_dot'(b.y)
          + t_dot'(a.z) * t_dot'(b.z);
        return s;
    endfunction

    function automatic t_nvec cross3(input t_dvec a, input t_dvec b);
        t_nvec r;
        r.x = t_dot'(a.y) * t_dot'(b.z) - t_dot'(a.z) * t_dot'(b.y);
        r.y = t_dot'(a.z) * t_dot'(b.x) - t_dot'(a.x) * t_dot'(b.z);
        r.z = t_dot'(a.x) * t_dot'(b.y) - t_dot'(a.y) * t_dot'(b.x);
        return r;
    endfunction

    function automatic t_wn dotn(input t_dvec w, input t_nvec n);
        t_wn s;
        s = t_wn'(w.x) * t_wn'(n.x) + t_wn'(w.y) * t_wn'(n.y)
          + t_wn'(w.z) * t_wn'(n.z);
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/scot_in_if.sv
// ----------------------------------------------------------------------------
// scot_in_if
// Valid/ready channel carrying one shape pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface scot_in_if;
    logic                 valid;
    logic                 ready;
    logic                 first_is_capsule;
    scot_pkg::t_raw       first_end_zero;
    scot_pkg::t_raw       first_end_one;
    scot_pkg::t_rad       first_radius;
    logic                 second_is_capsule;
    scot_pkg::t_raw       second_end_zero;
    scot_pkg::t_raw       second_end_one;
    scot_pkg::t_rad       second_radius;

    modport source (
        output valid, first_is_capsule, first_end_zero, first_end_one, first_radius,
        output second_is_capsule, second_end_zero, second_end_one, second_radius,
        input  ready
    );

    modport sink (
        input  valid, first_is_capsule, first_end_zero, first_end_one, first_radius,
        input  second_is_capsule, second_end_zero, second_end_one, second_radius,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/scot_out_if.sv
// ----------------------------------------------------------------------------
// scot_out_if
// Valid/ready channel carrying one overlap verdict.
// ----------------------------------------------------------------------------
`default_nettype none

interface scot_out_if;
    logic valid;
    logic ready;
    logic overlapping;

    modport source (output valid, overlapping, input ready);
    modport sink (input valid, overlapping, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sphere_capsule_overlap_test.sv
// ----------------------------------------------------------------------------
// sphere_capsule_overlap_test
// Overlap verdict for a pair of spheres/capsules, six-stage pipeline.
// ----------------------------------------------------------------------------
//
//   port     dir   handshake      carries
//   -------  ----  -------------  ------------------------------------------
//   i_req    in    valid / ready  shape kinds, end points, radii of a pair
//   o_rsp    out   valid / ready  overlapping: 1 when the cores come closer
//                                 than the sum of the radii
//
// One item enters per cycle when the output side keeps taking results.
// The product chain runs dots, products of dots, then the squared wn
// term against rsum^2 * |d1 x d2|^2, each step registered.
// Synchronous active-low reset clears the stage valid bits only.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// collapse under a stall and input ready drops only when all six stages
// hold an item and the output is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sphere_capsule_overlap_test_defines.svh"

module sphere_capsule_overlap_test (
    input  logic           i_clk,
    input  logic           i_rst_n,
    scot_in_if.sink        i_req,
    scot_out_if.source     o_rsp
);

    localparam int NST = scot_pkg::NSTAGE;

    scot_pkg::t_pipe_ctl w_ctl;
    scot_pkg::t_pair     w_pair;
    scot_pkg::t_prod     w_prod;
    logic                w_hit;
    logic [NST-1:0]      r_v, n_v;
    logic                w_in_acc;
    logic                w_out_acc;

    // Load enables: a stage advances when empty or when its successor moves
    always_comb begin
        w_ctl.en[NST-1] = !r_v[NST-1] || o_rsp.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_ctl.en[k] = !r_v[k] || w_ctl.en[k+1];
        end
    end

    // Valid bits travel with the data; hold while a stage is stalled
    always_comb begin
        n_v[0] = w_ctl.en[0] ? i_req.valid : r_v[0];
        for (int k = 1; k < NST; k++) begin
            n_v[k] = w_ctl.en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_comb begin
        w_pair.first_is_capsule  = i_req.first_is_capsule;
        w_pair.first_end_zero    = i_req.first_end_zero;
        w_pair.first_end_one     = i_req.first_end_one;
        w_pair.first_radius      = i_req.first_radius;
        w_pair.second_is_capsule = i_req.second_is_capsule;
        w_pair.second_end_zero   = i_req.second_end_zero;
        w_pair.second_end_one    = i_req.second_end_one;
        w_pair.second_radius     = i_req.second_radius;
    end

    scot_front u_front (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_pair (w_pair),
        .o_prod (w_prod)
    );

    scot_back u_back (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_prod (w_prod),
        .o_hit  (w_hit)
    );

    assign i_req.ready       = w_ctl.en[0];
    assign o_rsp.valid       = r_v[NST-1];
    assign o_rsp.overlapping = w_hit;

    assign w_in_acc  = i_req.valid && i_req.ready;
    assign w_out_acc = o_rsp.valid && o_rsp.ready;

    // Backpressure at the input only when the pipe is completely full
    `SCOT_ASSERT_NOW(a_full_when_blocked, !i_req.ready, &r_v, "input blocked with a free stage")
    // A taken result frees the pipe for a new item in the same cycle
    `SCOT_ASSERT_NOW(a_flow_through, o_rsp.ready, i_req.ready, "output taken but input blocked")
    // Items in flight change only by accepts and deliveries
    `SCOT_ASSERT_NEXT(a_item_count, 1'b1, $countones(r_v) == $past($countones(r_v)) + int'($past(w_in_acc)) - int'($past(w_out_acc)), "item lost or duplicated in pipe")

endmodule

`default_nettype wire

FILE: rtl/core/scot_front.sv
// ----------------------------------------------------------------------------
// scot_front
// Stages 1-3: differences, first-level dots and cross, second-level products.
// ----------------------------------------------------------------------------
`default_nettype none

module scot_front (
    input  logic                  i_clk,
    input  scot_pkg::t_pipe_ctl   i_ctl,
    input  scot_pkg::t_pair       i_pair,
    output scot_pkg::t_prod       o_prod
);

    typedef struct packed {
        scot_pkg::t_dvec d1;
        scot_pkg::t_dvec d2;
        scot_pkg::t_dvec w00;
        scot_pkg::t_dvec w01;
        scot_pkg::t_dvec w10;
        scot_pkg::t_dvec w11;
        scot_pkg::t_rsum rsum;
    } t_s1;

    typedef struct packed {
        scot_pkg::t_dot  a;
        scot_pkg::t_dot  b;
        scot_pkg::t_dot  c;
        scot_pkg::t_dot  dd;
        scot_pkg::t_dot  e;
        scot_pkg::t_dot  t2;
        scot_pkg::t_dot  f;
        scot_pkg::t_dot  q00;
        scot_pkg::t_dot  q01;
        scot_pkg::t_dot  q10;
        scot_pkg::t_dot  q11;
        scot_pkg::t_nvec n;
        scot_pkg::t_dvec w00;
        scot_pkg::t_dot  r2;
    } t_s2;

    scot_pkg::t_pt   p0, p1, q0, q1;
    t_s1             n_s1, r_s1;
    t_s2             n_s2, r_s2;
    scot_pkg::t_prod n_s3, r_s3;
    scot_pkg::t_dot  ww [4];
    scot_pkg::t_dot  tv [4];
    scot_pkg::t_dot  ln [4];
    scot_pkg::t_dot  vv [4];

    // Stage 1: a sphere is a capsule whose ends coincide
    always_comb begin
        p0 = scot_pkg::unpack(i_pair.first_end_zero);
        p1 = scot_pkg::unpack(i_pair.first_is_capsule ? i_pair.first_end_one
                                                      : i_pair.first_end_zero);
        q0 = scot_pkg::unpack(i_pair.second_end_zero);
        q1 = scot_pkg::unpack(i_pair.second_is_capsule ? i_pair.second_end_one
                                                       : i_pair.second_end_zero);
        n_s1.d1   = scot_pkg::vsub(p1, p0);
        n_s1.d2   = scot_pkg::vsub(q1, q0);
        n_s1.w00  = scot_pkg::vsub(p0, q0);
        n_s1.w01  = scot_pkg::vsub(p0, q1);
        n_s1.w10  = scot_pkg::vsub(p1, q0);
        n_s1.w11  = scot_pkg::vsub(p1, q1);
        n_s1.rsum = scot_pkg::t_rsum'(i_pair.first_radius)
                  + scot_pkg::t_rsum'(i_pair.second_radius);
    end

    // Stage 2: dot products, cross product, radius sum squared
    always_comb begin
        n_s2.a   = scot_pkg::dot3(r_s1.d1, r_s1.d1);
        n_s2.b   = scot_pkg::dot3(r_s1.d1, r_s1.d2);
        n_s2.c   = scot_pkg::dot3(r_s1.d2, r_s1.d2);
        n_s2.dd  = scot_pkg::dot3(r_s1.d1, r_s1.w00);
        n_s2.e   = scot_pkg::dot3(r_s1.d2, r_s1.w00);
        n_s2.t2  = scot_pkg::dot3(r_s1.d2, r_s1.w10);
        n_s2.f   = scot_pkg::dot3(r_s1.d1, r_s1.w01);
        n_s2.q00 = scot_pkg::dot3(r_s1.w00, r_s1.w00);
        n_s2.q01 = scot_pkg::dot3(r_s1.w01, r_s1.w01);
        n_s2.q10 = scot_pkg::dot3(r_s1.w10, r_s1.w10);
        n_s2.q11 = scot_pkg::dot3(r_s1.w11, r_s1.w11);
        n_s2.n   = scot_pkg::cross3(r_s1.d1, r_s1.d2);
        n_s2.w00 = r_s1.w00;
        n_s2.r2  = scot_pkg::t_dot'(scot_pkg::t_r2'(r_s1.rsum) * scot_pkg::t_r2'(r_s1.rsum));
    end

    // Endpoint tests: each end of one core against the other segment
    always_comb begin
        ww[0] = r_s2.q00;  tv[0] = r_s2.e;    ln[0] = r_s2.c;  vv[0] = r_s2.q01;
        ww[1] = r_s2.q10;  tv[1] = r_s2.t2;   ln[1] = r_s2.c;  vv[1] = r_s2.q11;
        ww[2] = r_s2.q00;  tv[2] = -r_s2.dd;  ln[2] = r_s2.a;  vv[2] = r_s2.q10;
        ww[3] = r_s2.q01;  tv[3] = -r_s2.f;   ln[3] = r_s2.a;  vv[3] = r_s2.q11;
    end

    // Stage 3: second-level products
    always_comb begin
        logic nar;
        logic ge;
        for (int i = 0; i < 4; i++) begin
            nar = (ln[i] == 0) || tv[i][scot_pkg::DOTW-1] || (tv[i] == 0);
            ge  = tv[i] >= ln[i];
            n_s3.nhit[i] = nar ? (ww[i] < r_s2.r2) : (ge && (vv[i] < r_s2.r2));
            n_s3.mid[i]  = !nar && !ge;
            n_s3.wwl[i]  = scot_pkg::t_p2'(ww[i]) * scot_pkg::t_p2'(ln[i]);
            n_s3.r2l[i]  = scot_pkg::t_p2'(r_s2.r2) * scot_pkg::t_p2'(ln[i]);
            n_s3.tt[i]   = scot_pkg::t_p2'(tv[i]) * scot_pkg::t_p2'(tv[i]);
        end
        n_s3.ac     = scot_pkg::t_p2'(r_s2.a) * scot_pkg::t_p2'(r_s2.c);
        n_s3.bb     = scot_pkg::t_p2'(r_s2.b) * scot_pkg::t_p2'(r_s2.b);
        n_s3.be     = scot_pkg::t_p2'(r_s2.b) * scot_pkg::t_p2'(r_s2.e);
        n_s3.cd     = scot_pkg::t_p2'(r_s2.c) * scot_pkg::t_p2'(r_s2.dd);
        n_s3.ae     = scot_pkg::t_p2'(r_s2.a) * scot_pkg::t_p2'(r_s2.e);
        n_s3.bd     = scot_pkg::t_p2'(r_s2.b) * scot_pkg::t_p2'(r_s2.dd);
        n_s3.nsq[0] = scot_pkg::t_p2'(r_s2.n.x) * scot_pkg::t_p2'(r_s2.n.x);
        n_s3.nsq[1] = scot_pkg::t_p2'(r_s2.n.y) * scot_pkg::t_p2'(r_s2.n.y);
        n_s3.nsq[2] = scot_pkg::t_p2'(r_s2.n.z) * scot_pkg::t_p2'(r_s2.n.z);
        n_s3.wn     = scot_pkg::dotn(r_s2.w00, r_s2.n);
        n_s3.r2     = scot_pkg::t_r2'(r_s2.r2);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_s1 <= n_s1;
        end
        if (i_ctl.en[1]) begin
            r_s2 <= n_s2;
        end
        if (i_ctl.en[2]) begin
            r_s3 <= n_s3;
        end
    end

    assign o_prod = r_s3;

endmodule

`default_nettype wire

FILE: rtl/core/scot_back.sv
// ----------------------------------------------------------------------------
// scot_back
// Stages 4-6: combine products, interior closest-point test, final verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module scot_back (
    input  logic                  i_clk,
    input  scot_pkg::t_pipe_ctl   i_ctl,
    input  scot_pkg::t_prod       i_prod,
    output logic                  o_hit
);

    localparam int HHW = 2 * scot_pkg::WN_HI;
    localparam int HLW = scot_pkg::WN_HI + scot_pkg::WN_LO;
    localparam int LLW = 2 * scot_pkg::WN_LO;
    localparam int RLW = scot_pkg::R2W + scot_pkg::NN_LO;
    localparam int RHW = scot_pkg::R2W + scot_pkg::NN_HI;

    typedef logic [scot_pkg::WNW-1:0] t_mag;
    typedef logic [HHW-1:0]           t_hh;
    typedef logic [HLW-1:0]           t_hl;
    typedef logic [LLW-1:0]           t_ll;
    typedef logic [RLW-1:0]           t_rlo;
    typedef logic [RHW-1:0]           t_rhi;
    typedef logic [scot_pkg::P2W:0]   t_sum;

    typedef struct packed {
        scot_pkg::t_wide den;
        scot_pkg::t_wide sn;
        scot_pkg::t_wide tn;
        scot_pkg::t_nn   nn;
        logic            pt_hit;
        t_hh             hh;
        t_hl             hl;
        t_ll             ll;
        scot_pkg::t_r2   r2;
    } t_s4;

    typedef struct packed {
        logic          gate;
        logic          pt_hit;
        scot_pkg::t_sq wn2;
        t_rlo          rn_lo;
        t_rhi          rn_hi;
    } t_s5;

    t_s4           n_s4, r_s4;
    t_s5           n_s5, r_s5;
    logic          n_hit, r_hit;
    t_mag          mag;
    scot_pkg::t_sq rhs;

    // Stage 4: wide differences, endpoint compares, split square of wn
    always_comb begin
        logic any;
        any = 1'b0;
        for (int i = 0; i < 4; i++) begin
            any = any | i_prod.nhit[i]
                | (i_prod.mid[i] && (t_sum'(i_prod.wwl[i])
                                     < t_sum'(i_prod.r2l[i]) + t_sum'(i_prod.tt[i])));
        end
        n_s4.pt_hit = any;
        n_s4.den = scot_pkg::t_wide'(i_prod.ac) - scot_pkg::t_wide'(i_prod.bb);
        n_s4.sn  = scot_pkg::t_wide'(i_prod.be) - scot_pkg::t_wide'(i_prod.cd);
        n_s4.tn  = scot_pkg::t_wide'(i_prod.ae) - scot_pkg::t_wide'(i_prod.bd);
        n_s4.nn  = scot_pkg::t_nn'(i_prod.nsq[0]) + scot_pkg::t_nn'(i_prod.nsq[1])
                 + scot_pkg::t_nn'(i_prod.nsq[2]);
        mag = i_prod.wn[scot_pkg::WNW-1] ? t_mag'(-i_prod.wn) : t_mag'(i_prod.wn);
        n_s4.hh = t_hh'(mag[scot_pkg::WNW-1:scot_pkg::WN_LO])
                * t_hh'(mag[scot_pkg::WNW-1:scot_pkg::WN_LO]);
        n_s4.hl = t_hl'(mag[scot_pkg::WNW-1:scot_pkg::WN_LO])
                * t_hl'(mag[scot_pkg::WN_LO-1:0]);
        n_s4.ll = t_ll'(mag[scot_pkg::WN_LO-1:0]) * t_ll'(mag[scot_pkg::WN_LO-1:0]);
        n_s4.r2 = i_prod.r2;
    end

    // Stage 5: closest points inside both segments; split r2 * |n|^2
    always_comb begin
        n_s5.gate = !r_s4.den[scot_pkg::WIDE-1] && (r_s4.den != 0)
                 && !r_s4.sn[scot_pkg::WIDE-1] && (r_s4.sn <= r_s4.den)
                 && !r_s4.tn[scot_pkg::WIDE-1] && (r_s4.tn <= r_s4.den);
        n_s5.pt_hit = r_s4.pt_hit;
        n_s5.wn2 = (scot_pkg::t_sq'(r_s4.hh) << (2 * scot_pkg::WN_LO))
                 + (scot_pkg::t_sq'(r_s4.hl) << (scot_pkg::WN_LO + 1))
                 + scot_pkg::t_sq'(r_s4.ll);
        n_s5.rn_lo = t_rlo'(r_s4.r2) * t_rlo'(r_s4.nn[scot_pkg::NN_LO-1:0]);
        n_s5.rn_hi = t_rhi'(r_s4.r2) * t_rhi'(r_s4.nn[scot_pkg::NNW-1:scot_pkg::NN_LO]);
    end

    // Stage 6: compare wn^2 against rsum^2 * |n|^2
    always_comb begin
        rhs = (scot_pkg::t_sq'(r_s5.rn_hi) << scot_pkg::NN_LO) + scot_pkg::t_sq'(r_s5.rn_lo);
        n_hit = r_s5.pt_hit || (r_s5.gate && (r_s5.wn2 < rhs));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_s4 <= n_s4;
        end
        if (i_ctl.en[4]) begin
            r_s5 <= n_s5;
        end
        if (i_ctl.en[5]) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule

`default_nettype wire
